// ===== design/ncd_pkg.sv =====
// ncd_pkg: shared types, constants and the microcode ROM of the negative
// cycle detector. No dependencies; used by every module but ncd_ram.
`default_nettype none

package ncd_pkg;

  // Fixed field widths of the ports
  localparam int VTX_BITS       = 9;
  localparam int WEIGHT_IN_BITS = 16;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_VERTICES = 256;
  localparam int DEF_MAX_EDGES    = 1024;
  localparam int DEF_WEIGHT_BITS  = 16;

  // Microcode address width
  localparam int UPC_BITS = 5;
  typedef logic [UPC_BITS-1:0] upc_t;

  // Named step addresses (jump targets)
  localparam upc_t UPC_START    = 5'd0;
  localparam upc_t UPC_SEEN_CLR = 5'd1;
  localparam upc_t UPC_VTX      = 5'd2;
  localparam upc_t UPC_VTX_CHK  = 5'd3;
  localparam upc_t UPC_RCLR     = 5'd4;
  localparam upc_t UPC_SRC      = 5'd5;
  localparam upc_t UPC_PASS     = 5'd6;
  localparam upc_t UPC_PASS_S   = 5'd7;
  localparam upc_t UPC_PASS_D   = 5'd8;
  localparam upc_t UPC_PASS_W   = 5'd9;
  localparam upc_t UPC_PASS_END = 5'd10;
  localparam upc_t UPC_CHECK    = 5'd11;
  localparam upc_t UPC_CHECK_S  = 5'd12;
  localparam upc_t UPC_CHECK_D  = 5'd13;
  localparam upc_t UPC_CHECK_T  = 5'd14;
  localparam upc_t UPC_CHECK_N  = 5'd15;
  localparam upc_t UPC_SUPD0    = 5'd16;
  localparam upc_t UPC_SUPD     = 5'd17;
  localparam upc_t UPC_SUPD_W   = 5'd18;
  localparam upc_t UPC_NEXTK    = 5'd19;
  localparam upc_t UPC_FIN0     = 5'd20;
  localparam upc_t UPC_FIN1     = 5'd21;

  // Memory operation of one step
  typedef enum logic [3:0] {
    MEM_NONE,
    MEM_SEEN_CLR,    // seen[j] <= 0
    MEM_SEEN_RD,     // read seen[k]
    MEM_DIST_CLR,    // dist[j] <= unreached
    MEM_DIST_SRC,    // dist[k] <= reached, 0
    MEM_EDGE_RD,     // read edge[j]
    MEM_DIST_RD_SRC, // read dist[src]
    MEM_DIST_RD_DST, // read dist[dst], latch dist[src]
    MEM_RELAX,       // write dist[dst] if the edge relaxes
    MEM_DIST_RD_J,   // read dist[j]
    MEM_SEEN_SET     // seen[j] <= 1 if dist[j] reached
  } mem_op_t;

  // Counter operation
  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_CLR,
    CNT_ONE,
    CNT_INC
  } cnt_op_t;

  // Jump condition
  typedef enum logic [3:0] {
    COND_NONE,
    COND_NV_ZERO,
    COND_NV_ONE,
    COND_V_MORE,
    COND_E_MORE,
    COND_K_MORE,
    COND_P_MORE,
    COND_SEEN,
    COND_HIT
  } cond_sel_t;

  // End of search
  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_CLEAR, // result 0
    FIN_FLAG   // result 1
  } fin_op_t;

  typedef struct packed {
    mem_op_t   mem;
    cnt_op_t   j_op;
    cnt_op_t   k_op;
    cnt_op_t   p_op;
    cond_sel_t cond;
    upc_t      target;
    fin_op_t   fin;
  } ctrl_word_t;

  // Status flags from the datapath for jump evaluation
  typedef struct packed {
    logic nv_zero;
    logic nv_one;
    logic v_more;
    logic e_more;
    logic k_more;
    logic p_more;
    logic seen;
    logic hit;
  } cond_flags_t;

  function automatic ctrl_word_t cw(input mem_op_t m, input cnt_op_t jo,
                                    input cnt_op_t ko, input cnt_op_t po,
                                    input cond_sel_t c, input upc_t t,
                                    input fin_op_t f);
    ctrl_word_t w;
    w.mem    = m;
    w.j_op   = jo;
    w.k_op   = ko;
    w.p_op   = po;
    w.cond   = c;
    w.target = t;
    w.fin    = f;
    return w;
  endfunction

  // Control word issued while the sequencer is idle
  function automatic ctrl_word_t idle_word();
    return cw(MEM_NONE, CNT_KEEP, CNT_KEEP, CNT_KEEP, COND_NONE, UPC_START, FIN_NONE);
  endfunction

  // Microcode ROM: Bellman-Ford from every unseen source vertex
  function automatic ctrl_word_t ucode(input upc_t a);
    ctrl_word_t w;
    case (a)
      // j, k <= 0; empty vertex range ends at once
      UPC_START:    w = cw(MEM_NONE, CNT_CLR, CNT_CLR, CNT_KEEP,
                           COND_NV_ZERO, UPC_FIN0, FIN_NONE);
      // clear the seen map
      UPC_SEEN_CLR: w = cw(MEM_SEEN_CLR, CNT_INC, CNT_KEEP, CNT_KEEP,
                           COND_V_MORE, UPC_SEEN_CLR, FIN_NONE);
      // per source k: skip if already seen
      UPC_VTX:      w = cw(MEM_SEEN_RD, CNT_CLR, CNT_KEEP, CNT_KEEP,
                           COND_NONE, UPC_START, FIN_NONE);
      UPC_VTX_CHK:  w = cw(MEM_NONE, CNT_KEEP, CNT_KEEP, CNT_KEEP,
                           COND_SEEN, UPC_NEXTK, FIN_NONE);
      // mark all vertices unreached, then seed the source
      UPC_RCLR:     w = cw(MEM_DIST_CLR, CNT_INC, CNT_KEEP, CNT_KEEP,
                           COND_V_MORE, UPC_RCLR, FIN_NONE);
      UPC_SRC:      w = cw(MEM_DIST_SRC, CNT_CLR, CNT_KEEP, CNT_ONE,
                           COND_NV_ONE, UPC_CHECK, FIN_NONE);
      // relaxation passes, four steps per edge
      UPC_PASS:     w = cw(MEM_EDGE_RD, CNT_KEEP, CNT_KEEP, CNT_KEEP,
                           COND_NONE, UPC_START, FIN_NONE);
      UPC_PASS_S:   w = cw(MEM_DIST_RD_SRC, CNT_KEEP, CNT_KEEP, CNT_KEEP,
                           COND_NONE, UPC_START, FIN_NONE);
      UPC_PASS_D:   w = cw(MEM_DIST_RD_DST, CNT_KEEP, CNT_KEEP, CNT_KEEP,
                           COND_NONE, UPC_START, FIN_NONE);
      UPC_PASS_W:   w = cw(MEM_RELAX, CNT_INC, CNT_KEEP, CNT_KEEP,
                           COND_E_MORE, UPC_PASS, FIN_NONE);
      UPC_PASS_END: w = cw(MEM_NONE, CNT_CLR, CNT_KEEP, CNT_INC,
                           COND_P_MORE, UPC_PASS, FIN_NONE);
      // check pass: any edge that still relaxes ends the search
      UPC_CHECK:    w = cw(MEM_EDGE_RD, CNT_KEEP, CNT_KEEP, CNT_KEEP,
                           COND_NONE, UPC_START, FIN_NONE);
      UPC_CHECK_S:  w = cw(MEM_DIST_RD_SRC, CNT_KEEP, CNT_KEEP, CNT_KEEP,
                           COND_NONE, UPC_START, FIN_NONE);
      UPC_CHECK_D:  w = cw(MEM_DIST_RD_DST, CNT_KEEP, CNT_KEEP, CNT_KEEP,
                           COND_NONE, UPC_START, FIN_NONE);
      UPC_CHECK_T:  w = cw(MEM_NONE, CNT_KEEP, CNT_KEEP, CNT_KEEP,
                           COND_HIT, UPC_FIN1, FIN_NONE);
      UPC_CHECK_N:  w = cw(MEM_NONE, CNT_INC, CNT_KEEP, CNT_KEEP,
                           COND_E_MORE, UPC_CHECK, FIN_NONE);
      // fold reached vertices into the seen map
      UPC_SUPD0:    w = cw(MEM_NONE, CNT_CLR, CNT_KEEP, CNT_KEEP,
                           COND_NONE, UPC_START, FIN_NONE);
      UPC_SUPD:     w = cw(MEM_DIST_RD_J, CNT_KEEP, CNT_KEEP, CNT_KEEP,
                           COND_NONE, UPC_START, FIN_NONE);
      UPC_SUPD_W:   w = cw(MEM_SEEN_SET, CNT_INC, CNT_KEEP, CNT_KEEP,
                           COND_V_MORE, UPC_SUPD, FIN_NONE);
      UPC_NEXTK:    w = cw(MEM_NONE, CNT_KEEP, CNT_INC, CNT_KEEP,
                           COND_K_MORE, UPC_VTX, FIN_NONE);
      UPC_FIN0:     w = cw(MEM_NONE, CNT_KEEP, CNT_KEEP, CNT_KEEP,
                           COND_NONE, UPC_START, FIN_CLEAR);
      UPC_FIN1:     w = cw(MEM_NONE, CNT_KEEP, CNT_KEEP, CNT_KEEP,
                           COND_NONE, UPC_START, FIN_FLAG);
      default:      w = cw(MEM_NONE, CNT_KEEP, CNT_KEEP, CNT_KEEP,
                           COND_NONE, UPC_START, FIN_CLEAR);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/ncd_ram.sv =====
// ncd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ncd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/ncd_sequencer.sv =====
// ncd_sequencer: step counter and microcode ROM with conditional jumps.
// Depends on ncd_pkg (control word, flags, ROM contents).
`default_nettype none

module ncd_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  ncd_pkg::cond_flags_t flags,
  output ncd_pkg::ctrl_word_t  ctrl,
  output logic                 busy
);
  import ncd_pkg::*;

  upc_t upc_r, upc_nxt;
  logic busy_r, busy_nxt;
  logic taken;

  // current control word
  always_comb begin
    if (busy_r) begin
      ctrl = ucode(upc_r);
    end else begin
      ctrl = idle_word();
    end
  end

  // jump condition
  always_comb begin
    case (ctrl.cond)
      COND_NONE:    taken = 1'b0;
      COND_NV_ZERO: taken = flags.nv_zero;
      COND_NV_ONE:  taken = flags.nv_one;
      COND_V_MORE:  taken = flags.v_more;
      COND_E_MORE:  taken = flags.e_more;
      COND_K_MORE:  taken = flags.k_more;
      COND_P_MORE:  taken = flags.p_more;
      COND_SEEN:    taken = flags.seen;
      COND_HIT:     taken = flags.hit;
      default:      taken = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (!busy_r) begin
      if (go) begin
        busy_nxt = 1'b1;
        upc_nxt  = UPC_START;
      end
    end else if (ctrl.fin != FIN_NONE) begin
      busy_nxt = 1'b0;
      upc_nxt  = UPC_START;
    end else if (taken) begin
      upc_nxt = ctrl.target;
    end else begin
      upc_nxt = UPC_BITS'(upc_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= UPC_START;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

  assign busy = busy_r;

  // a search always begins at the first step
  a_go_start: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !busy_r) |=> (busy_r && upc_r == UPC_START))
    else $error("search did not start at first step");

  // a finishing step releases the block
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && ctrl.fin != FIN_NONE) |=> !busy_r)
    else $error("sequencer stayed busy after finish");

endmodule

`default_nettype wire

// ===== design/ncd_datapath.sv =====
// ncd_datapath: edge store, distance and seen memories, loop counters and
// the relax unit, driven by the microcode word. Depends on ncd_pkg, ncd_ram.
`default_nettype none

module ncd_datapath #(
  parameter int MAX_VERTICES = ncd_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = ncd_pkg::DEF_MAX_EDGES,
  parameter int WEIGHT_BITS  = ncd_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  ncd_pkg::ctrl_word_t                       ctrl,
  input  logic                                      accept,
  input  logic [ncd_pkg::VTX_BITS-1:0]              from_vertex,
  input  logic [ncd_pkg::VTX_BITS-1:0]              to_vertex,
  input  logic signed [ncd_pkg::WEIGHT_IN_BITS-1:0] edge_weight,
  input  logic                                      cfg_we,
  input  logic [ncd_pkg::VTX_BITS-1:0]              cfg_vertex_count,
  output ncd_pkg::cond_flags_t                      flags,
  output logic                                      out_valid,
  output logic                                      out_flag
);
  import ncd_pkg::*;

  localparam int EIDX_BITS = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int VIDX_BITS = $clog2(MAX_VERTICES);
  localparam int EC_BITS   = $clog2(MAX_EDGES + 1);
  localparam int J_BITS    = (EC_BITS > VTX_BITS) ? EC_BITS : VTX_BITS;
  // walk length bound: vertices * edges relaxations of max weight
  localparam int DIST_BITS = WEIGHT_BITS + $clog2(MAX_VERTICES) + $clog2(MAX_EDGES) + 2;
  localparam int EDGE_BITS = 2 * VTX_BITS + WEIGHT_BITS;

  // configuration and counters
  logic [VTX_BITS-1:0] vc_r, vc_nxt;
  logic [VTX_BITS-1:0] nv;
  logic [EC_BITS-1:0]  edge_total_r, edge_total_nxt;
  logic [J_BITS-1:0]   j_r, j_nxt;
  logic [VTX_BITS-1:0] k_r, k_nxt;
  logic [VTX_BITS-1:0] p_r, p_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_flag_r, out_flag_nxt;
  logic [DIST_BITS:0]  dsrc_r;

  // edge store ports
  logic                  edge_we;
  logic [EDGE_BITS-1:0]  edge_wdata;
  logic [EDGE_BITS-1:0]  edge_rdata;
  logic [WEIGHT_BITS-1:0] wt_in;

  // distance store ports: {reached, distance}
  logic                 dist_we;
  logic [VIDX_BITS-1:0] dist_waddr, dist_raddr;
  logic [DIST_BITS:0]   dist_wdata, dist_rdata;
  logic                 dist_re;

  // seen map ports
  logic                 seen_we, seen_wdata, seen_re, seen_rdata;
  logic [VIDX_BITS-1:0] seen_waddr;

  // relax unit
  logic [VTX_BITS-1:0]         e_src, e_dst;
  logic [WEIGHT_BITS-1:0]      e_wt;
  logic [VIDX_BITS-1:0]        src_idx, dst_idx;
  logic                        e_ok, hit;
  logic signed [DIST_BITS-1:0] d_src, d_dst, cand;

  // effective vertex count, capped at the store depth
  assign nv = (32'(vc_r) > MAX_VERTICES) ? VTX_BITS'(MAX_VERTICES) : vc_r;

  // low WEIGHT_BITS of the zero-extended field
  assign wt_in      = WEIGHT_BITS'(32'($unsigned(edge_weight)));
  assign edge_we    = accept && (32'(edge_total_r) < MAX_EDGES);
  assign edge_wdata = {from_vertex, to_vertex, wt_in};

  ncd_ram #(.WIDTH(EDGE_BITS), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (EIDX_BITS'(edge_total_r)),
    .wdata (edge_wdata),
    .re    (ctrl.mem == MEM_EDGE_RD),
    .raddr (EIDX_BITS'(j_r)),
    .rdata (edge_rdata)
  );

  // unpack the fetched edge
  assign e_src   = edge_rdata[EDGE_BITS-1 -: VTX_BITS];
  assign e_dst   = edge_rdata[WEIGHT_BITS +: VTX_BITS];
  assign e_wt    = edge_rdata[WEIGHT_BITS-1:0];
  assign src_idx = VIDX_BITS'(32'(e_src) - 32'd1);
  assign dst_idx = VIDX_BITS'(32'(e_dst) - 32'd1);
  assign e_ok    = (e_src != '0) && (e_dst != '0) && (e_src <= nv) && (e_dst <= nv);

  // relax test: dsrc_r holds dist[src], read data holds dist[dst]
  assign d_src = $signed(dsrc_r[DIST_BITS-1:0]);
  assign d_dst = $signed(dist_rdata[DIST_BITS-1:0]);
  assign cand  = d_src + DIST_BITS'($signed(e_wt));
  assign hit   = e_ok && dsrc_r[DIST_BITS] && (!dist_rdata[DIST_BITS] || (cand < d_dst));

  // distance store access
  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = VIDX_BITS'(j_r);
    dist_wdata = '0;
    dist_re    = 1'b0;
    dist_raddr = VIDX_BITS'(j_r);
    case (ctrl.mem)
      MEM_DIST_CLR: begin
        dist_we = 1'b1;
      end
      MEM_DIST_SRC: begin
        dist_we    = 1'b1;
        dist_waddr = VIDX_BITS'(k_r);
        dist_wdata = {1'b1, {DIST_BITS{1'b0}}};
      end
      MEM_DIST_RD_SRC: begin
        dist_re    = 1'b1;
        dist_raddr = src_idx;
      end
      MEM_DIST_RD_DST: begin
        dist_re    = 1'b1;
        dist_raddr = dst_idx;
      end
      MEM_RELAX: begin
        dist_we    = hit;
        dist_waddr = dst_idx;
        dist_wdata = {1'b1, cand};
      end
      MEM_DIST_RD_J: begin
        dist_re = 1'b1;
      end
      default: begin
        dist_we = 1'b0;
      end
    endcase
  end

  ncd_ram #(.WIDTH(DIST_BITS + 1), .DEPTH(MAX_VERTICES)) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .re    (dist_re),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  // seen map access
  always_comb begin
    seen_we    = 1'b0;
    seen_wdata = 1'b0;
    seen_waddr = VIDX_BITS'(j_r);
    case (ctrl.mem)
      MEM_SEEN_CLR: seen_we = 1'b1;
      MEM_SEEN_SET: begin
        seen_we    = dist_rdata[DIST_BITS];
        seen_wdata = 1'b1;
      end
      default:      seen_we = 1'b0;
    endcase
  end

  assign seen_re = (ctrl.mem == MEM_SEEN_RD);

  ncd_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_seen_ram (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (seen_wdata),
    .re    (seen_re),
    .raddr (VIDX_BITS'(k_r)),
    .rdata (seen_rdata)
  );

  // loop counters
  always_comb begin
    case (ctrl.j_op)
      CNT_CLR: j_nxt = '0;
      CNT_ONE: j_nxt = J_BITS'(1);
      CNT_INC: j_nxt = J_BITS'(j_r + 1'b1);
      default: j_nxt = j_r;
    endcase
    case (ctrl.k_op)
      CNT_CLR: k_nxt = '0;
      CNT_ONE: k_nxt = VTX_BITS'(1);
      CNT_INC: k_nxt = VTX_BITS'(k_r + 1'b1);
      default: k_nxt = k_r;
    endcase
    case (ctrl.p_op)
      CNT_CLR: p_nxt = '0;
      CNT_ONE: p_nxt = VTX_BITS'(1);
      CNT_INC: p_nxt = VTX_BITS'(p_r + 1'b1);
      default: p_nxt = p_r;
    endcase
  end

  // edge count, config and result
  always_comb begin
    vc_nxt         = cfg_we ? cfg_vertex_count : vc_r;
    edge_total_nxt = edge_total_r;
    out_valid_nxt  = 1'b0;
    out_flag_nxt   = out_flag_r;
    if (ctrl.fin != FIN_NONE) begin
      edge_total_nxt = '0;
      out_valid_nxt  = 1'b1;
      out_flag_nxt   = (ctrl.fin == FIN_FLAG);
    end else if (edge_we) begin
      edge_total_nxt = EC_BITS'(edge_total_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r         <= VTX_BITS'(1);
      edge_total_r <= '0;
      j_r          <= '0;
      k_r          <= '0;
      p_r          <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      vc_r         <= vc_nxt;
      edge_total_r <= edge_total_nxt;
      j_r          <= j_nxt;
      k_r          <= k_nxt;
      p_r          <= p_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_flag_r <= out_flag_nxt;
    if (ctrl.mem == MEM_DIST_RD_DST) begin
      dsrc_r <= dist_rdata;
    end
  end

  // status flags for the sequencer
  assign flags.nv_zero = (nv == '0);
  assign flags.nv_one  = (nv == VTX_BITS'(1));
  assign flags.v_more  = (32'(j_r) + 32'd1) < 32'(nv);
  assign flags.e_more  = (32'(j_r) + 32'd1) < 32'(edge_total_r);
  assign flags.k_more  = (32'(k_r) + 32'd1) < 32'(nv);
  assign flags.p_more  = (32'(p_r) + 32'd1) < 32'(nv);
  assign flags.seen    = seen_rdata;
  assign flags.hit     = hit;

  assign out_valid = out_valid_r;
  assign out_flag  = out_flag_r;

  // a finished search leaves an empty edge list and one result beat
  a_fin_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.fin != FIN_NONE) |=> (edge_total_r == '0 && out_valid_r))
    else $error("finish did not clear edges or raise result");

  // results are single-cycle beats
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

endmodule

`default_nettype wire

// ===== design/negative_cycle_detector.sv =====
// negative_cycle_detector: top level, command-style edge input and a
// one-cycle result strobe. Depends on ncd_pkg, ncd_sequencer, ncd_datapath.
//
// Edges load one per cycle while busy is low; up to MAX_EDGES of them are
// written straight into the edge store. An edge with in_last_edge set
// raises busy and starts the search; busy stays high until the result beat.
// The result appears on out_has_negative_cycle for exactly one cycle with
// out_valid, and the receiver cannot stall it. The search is run by a
// microcoded sequencer over memories with one write and one read port each;
// with nv vertices and E stored edges it skips every source already seen
// and ends early on the first edge found to relax in a check pass. Edge
// relaxation is split into separate steps because the distance memory has
// one read port. The seen map is cleared at the start of every search, so
// no pass is needed after reset. cfg_vertex_count is taken only while busy
// is low.
`default_nettype none

module negative_cycle_detector #(
  parameter int MAX_VERTICES = ncd_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = ncd_pkg::DEF_MAX_EDGES,
  parameter int WEIGHT_BITS  = ncd_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // edge input
  input  logic                                      start,
  output logic                                      busy,
  input  logic [ncd_pkg::VTX_BITS-1:0]              in_from_vertex,
  input  logic [ncd_pkg::VTX_BITS-1:0]              in_to_vertex,
  input  logic signed [ncd_pkg::WEIGHT_IN_BITS-1:0] in_edge_weight,
  input  logic                                      in_last_edge,
  // result
  output logic                                      out_valid,
  output logic                                      out_has_negative_cycle,
  // configuration
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [ncd_pkg::VTX_BITS-1:0]              cfg_vertex_count
);
  import ncd_pkg::*;

  ctrl_word_t  ctrl;
  cond_flags_t flags;
  logic        accept;
  logic        go;

  // handshake
  assign accept    = start && !busy;
  assign go        = accept && in_last_edge;
  assign cfg_ready = !busy;

  ncd_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  ncd_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .accept           (accept),
    .from_vertex      (in_from_vertex),
    .to_vertex        (in_to_vertex),
    .edge_weight      (in_edge_weight),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_vertex_count (cfg_vertex_count),
    .flags            (flags),
    .out_valid        (out_valid),
    .out_flag         (out_has_negative_cycle)
  );

endmodule

`default_nettype wire
